### rtl/core/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

   localparam int ADDR_W         = 32;
   localparam int BC_W           = 11;
   localparam int NUM_BLOCKS_DEF = 1024;
   // Block size must stay a power of two: address to index is a shift.
   localparam int BLOCK_SIZE     = 4096;
   localparam int BLOCK_SHIFT    = $clog2(BLOCK_SIZE);

   localparam logic [ADDR_W-1:0] HEAP_BASE_RST   = '0;
   localparam logic [BC_W-1:0]   BLOCK_COUNT_RST = 11'd1024;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOMEM   = 2'd1,
      ST_BADSIZE = 2'd2,
      ST_RANGE   = 2'd3
   } status_type;

   typedef enum logic {
      CSR_HEAP_BASE   = 1'b0,
      CSR_BLOCK_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      FS_INIT,
      FS_IDLE,
      FS_DECODE,
      FS_SCAN,
      FS_MARK,
      FS_FREE,
      FS_DONE
   } state_type;

   typedef struct packed {
      logic has_next;
      logic first;
      logic taken;
   } entry_type;

endpackage

### rtl/core/first_fit_block_allocator_top.sv
// First-fit block-table heap allocator: table memory, sequencer and register port.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------
//   req     | in        | req_valid / req_ready | req_cmd, req_size_bytes,
//           |           |                       | req_free_addr
//   rsp     | out       | rsp_valid / rsp_ready | rsp_alloc_addr, rsp_status
//   csr     | in        | csr_we                | csr_index, csr_wdata
//
// One transaction is worked at a time, driven by the single read port of the
// block table. Allocate decodes, scans entries and marks the run before it
// hands off; free decodes and walks the chain. Clear sweeps the whole table.
// After reset the same sweep runs with req_ready low; register writes are
// taken during it.
// A finished result waits in the output register; the next request is accepted
// while it waits, and only the final hand-off stalls on rsp_ready.
module first_fit_block_allocator_top
   import ffba_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic [ADDR_W-1:0] req_size_bytes,
   input  logic [ADDR_W-1:0] req_free_addr,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ADDR_W-1:0] rsp_alloc_addr,
   output logic [1:0]        rsp_status,
   // register write port
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [ADDR_W-1:0] csr_wdata
);

   localparam int IDX_W  = $clog2(NUM_BLOCKS);
   localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
   localparam int NEED_W = ADDR_W + 1 - BLOCK_SHIFT;

   // configuration registers
   logic [ADDR_W-1:0] heap_base_ff;
   logic [BC_W-1:0]   block_count_ff;

   // sequencer state
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  i_ff, i_in;          // table index being worked
   logic [IDX_W-1:0]  start_ff, start_in;  // start of the current free run
   logic [CNT_W-1:0]  run_ff, run_in;      // length of the current free run
   logic [CNT_W-1:0]  need_ff, need_in;    // blocks requested
   logic [CNT_W-1:0]  cnt_ff, cnt_in;      // blocks marked so far
   logic              clr_rsp_ff, clr_rsp_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic [ADDR_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] faddr_ff, faddr_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   status_type        res_status_ff, res_status_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_alloc_addr_ff, rsp_alloc_addr_in;
   status_type        rsp_status_ff, rsp_status_in;

   // block table
   entry_type         mem [NUM_BLOCKS];
   entry_type         mem_rdata_ff;
   logic              mem_re, mem_we;
   logic [IDX_W-1:0]  mem_raddr, mem_waddr;
   entry_type         mem_wdata;

   // derived values
   logic [CNT_W-1:0]  n_used;
   logic [ADDR_W:0]   size_round;
   logic [NEED_W-1:0] need_full;
   logic [ADDR_W-1:0] free_off;
   logic [ADDR_W-1:0] free_idx;
   logic [CNT_W-1:0]  i_next_cnt;
   logic              run_hit;

   // block_count above the table depth acts as the table depth
   assign n_used = ({{(ADDR_W-BC_W){1'b0}}, block_count_ff} > ADDR_W'(NUM_BLOCKS)) ?
                   CNT_W'(NUM_BLOCKS) : CNT_W'(block_count_ff);

   assign size_round = {1'b0, size_ff} + (ADDR_W+1)'(BLOCK_SIZE - 1);
   assign need_full  = size_round[ADDR_W:BLOCK_SHIFT];
   assign free_off   = faddr_ff - heap_base_ff;
   assign free_idx   = free_off >> BLOCK_SHIFT;
   assign i_next_cnt = CNT_W'(i_ff) + CNT_W'(1);
   assign run_hit    = !mem_rdata_ff.taken && ((run_ff + CNT_W'(1)) == need_ff);

   assign req_ready      = (state_ff == FS_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alloc_addr = rsp_alloc_addr_ff;
   assign rsp_status     = rsp_status_ff;

   // register write port
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff   <= HEAP_BASE_RST;
         block_count_ff <= BLOCK_COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HEAP_BASE:   heap_base_ff   <= csr_wdata;
            CSR_BLOCK_COUNT: block_count_ff <= csr_wdata[BC_W-1:0];
            default:         heap_base_ff   <= heap_base_ff;
         endcase
      end
   end

   // block table: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FS_INIT;
         i_ff         <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      start_ff          <= start_in;
      run_ff            <= run_in;
      need_ff           <= need_in;
      cnt_ff            <= cnt_in;
      cmd_ff            <= cmd_in;
      size_ff           <= size_in;
      faddr_ff          <= faddr_in;
      res_addr_ff       <= res_addr_in;
      res_status_ff     <= res_status_in;
      rsp_alloc_addr_ff <= rsp_alloc_addr_in;
      rsp_status_ff     <= rsp_status_in;
   end

   // next state and table access
   always_comb begin
      state_in          = state_ff;
      i_in              = i_ff;
      start_in          = start_ff;
      run_in            = run_ff;
      need_in           = need_ff;
      cnt_in            = cnt_ff;
      clr_rsp_in        = clr_rsp_ff;
      cmd_in            = cmd_ff;
      size_in           = size_ff;
      faddr_in          = faddr_ff;
      res_addr_in       = res_addr_ff;
      res_status_in     = res_status_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_alloc_addr_in = rsp_alloc_addr_ff;
      rsp_status_in     = rsp_status_ff;
      mem_re            = 1'b0;
      mem_raddr         = i_ff;
      mem_we            = 1'b0;
      mem_waddr         = i_ff;
      mem_wdata         = '0;

      unique case (state_ff)
         // sweep every entry to free; after reset no response follows
         FS_INIT: begin
            mem_we = 1'b1;
            i_in   = i_ff + IDX_W'(1);
            if (i_ff == IDX_W'(NUM_BLOCKS - 1)) begin
               i_in = '0;
               if (clr_rsp_ff) begin
                  clr_rsp_in    = 1'b0;
                  res_addr_in   = '0;
                  res_status_in = ST_OK;
                  state_in      = FS_DONE;
               end else begin
                  state_in = FS_IDLE;
               end
            end
         end

         FS_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               size_in  = req_size_bytes;
               faddr_in = req_free_addr;
               state_in = FS_DECODE;
            end
         end

         // check the request and, for a valid allocate or free, issue the first table read
         FS_DECODE: begin
            res_addr_in   = '0;
            res_status_in = ST_OK;
            run_in        = '0;
            i_in          = '0;
            state_in      = FS_DONE;
            case (cmd_ff)
               CMD_ALLOC: begin
                  if (size_ff == '0) begin
                     res_status_in = ST_BADSIZE;
                  end else if ((ADDR_W+1)'(need_full) > (ADDR_W+1)'(n_used)) begin
                     res_status_in = ST_NOMEM;
                  end else begin
                     need_in   = CNT_W'(need_full);
                     mem_re    = 1'b1;
                     mem_raddr = '0;
                     state_in  = FS_SCAN;
                  end
               end
               CMD_FREE: begin
                  if ((faddr_ff < heap_base_ff) || (free_idx >= ADDR_W'(n_used))) begin
                     res_status_in = ST_RANGE;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = IDX_W'(free_idx);
                     i_in      = IDX_W'(free_idx);
                     state_in  = FS_FREE;
                  end
               end
               CMD_CLEAR: begin
                  clr_rsp_in = 1'b1;
                  state_in   = FS_INIT;
               end
               default: begin
                  state_in = FS_DONE;
               end
            endcase
         end

         // data for entry i_ff is in the read register; read ahead one entry
         FS_SCAN: begin
            if (mem_rdata_ff.taken) begin
               run_in = '0;
            end else begin
               if (run_ff == '0) begin
                  start_in = i_ff;
               end
               run_in = run_ff + CNT_W'(1);
            end
            if (run_hit) begin
               i_in     = (run_ff == '0) ? i_ff : start_ff;
               cnt_in   = '0;
               state_in = FS_MARK;
            end else if (i_next_cnt == n_used) begin
               res_status_in = ST_NOMEM;
               state_in      = FS_DONE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = i_ff + IDX_W'(1);
               i_in      = i_ff + IDX_W'(1);
            end
         end

         // write the run, one entry a cycle
         FS_MARK: begin
            mem_we             = 1'b1;
            mem_wdata.taken    = 1'b1;
            mem_wdata.first    = (cnt_ff == '0);
            mem_wdata.has_next = ((cnt_ff + CNT_W'(1)) < need_ff);
            i_in               = i_ff + IDX_W'(1);
            cnt_in             = cnt_ff + CNT_W'(1);
            if ((cnt_ff + CNT_W'(1)) == need_ff) begin
               res_addr_in   = heap_base_ff + (ADDR_W'(start_ff) << BLOCK_SHIFT);
               res_status_in = ST_OK;
               state_in      = FS_DONE;
            end
         end

         // clear the entry and follow its has-next mark
         FS_FREE: begin
            mem_we = 1'b1;
            if (mem_rdata_ff.has_next && (i_next_cnt < n_used)) begin
               mem_re    = 1'b1;
               mem_raddr = i_ff + IDX_W'(1);
               i_in      = i_ff + IDX_W'(1);
            end else begin
               res_status_in = ST_OK;
               state_in      = FS_DONE;
            end
         end

         // hand the result to the output register once it is free
         FS_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_alloc_addr_in = res_addr_ff;
               rsp_status_in     = res_status_ff;
               state_in          = FS_IDLE;
            end
         end

         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   // a response appears only as the sequencer leaves its done state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == FS_DONE))
      else $error("response raised outside the done state");

   // marking never writes more entries than were requested
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == FS_MARK) |-> (cnt_ff < need_ff))
      else $error("run marking overran the request");

   // a granted address lies on a block boundary counted from the heap base
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_OK) && (rsp_alloc_addr_ff != '0)) |->
      (((rsp_alloc_addr_ff - heap_base_ff) & ADDR_W'(BLOCK_SIZE - 1)) == '0))
      else $error("granted address not block aligned");

endmodule

### bench/first_fit_block_allocator_top_tb.sv
// Self-checking testbench for the first-fit block-table heap allocator.
module first_fit_block_allocator_top_tb;
   import ffba_pkg::*;

   // cmd code that the block must take as a no-op that still answers ok
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned MAX_REPORTS = 10;
   // cycles for one worst-case allocate at full table depth, plus margin
   localparam int unsigned DRAIN_CYCLES = 2 * NUM_BLOCKS_DEF + 64;

   typedef struct {
      logic [ADDR_W-1:0] addr;
      status_type        status;
   } heap_reply_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_cmd = CMD_ALLOC;
   logic [ADDR_W-1:0] req_size_bytes = '0;
   logic [ADDR_W-1:0] req_free_addr = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [ADDR_W-1:0] rsp_alloc_addr;
   logic [1:0]        rsp_status;
   logic              csr_we = 1'b0;
   logic              csr_index = CSR_HEAP_BASE;
   logic [ADDR_W-1:0] csr_wdata = '0;

   first_fit_block_allocator_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_size_bytes (req_size_bytes),
      .req_free_addr  (req_free_addr),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_alloc_addr (rsp_alloc_addr),
      .rsp_status     (rsp_status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Heap predictor: own copy of the block table and the two registers.
   // ---------------------------------------------------------------------
   entry_type         block_marks [NUM_BLOCKS_DEF];
   logic [ADDR_W-1:0] heap_base_q = HEAP_BASE_RST;
   logic [BC_W-1:0]   block_count_q = BLOCK_COUNT_RST;

   // replies still owed by the block, oldest first
   heap_reply_type    owed_replies[$];
   // addresses handed out and not yet released; feeds well-formed frees
   logic [ADDR_W-1:0] live_blocks[$];
   int unsigned       fail_count = 0;

   function automatic int unsigned blocks_in_use();
      return (block_count_q > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : block_count_q;
   endfunction

   function automatic heap_reply_type carve_run(logic [ADDR_W-1:0] size);
      heap_reply_type   res;
      longint unsigned  need;
      int unsigned      n, run, start, i;
      bit               found;
      res.addr = '0;
      res.status = ST_OK;
      n = blocks_in_use();
      run = 0;
      start = 0;
      found = 1'b0;
      if (size == '0) begin
         res.status = ST_BADSIZE;
         return res;
      end
      need = (64'(size) + 64'(BLOCK_SIZE) - 64'd1) / 64'(BLOCK_SIZE);
      if (need > n) begin
         res.status = ST_NOMEM;
         return res;
      end
      // lowest run of free entries, reset by every taken entry
      for (i = 0; i < n; i++) begin
         if (block_marks[i].taken) begin
            run = 0;
         end else begin
            if (run == 0) start = i;
            run++;
            if (run == need) begin
               found = 1'b1;
               break;
            end
         end
      end
      if (!found) begin
         res.status = ST_NOMEM;
         return res;
      end
      for (i = 0; i < need; i++) begin
         block_marks[start + i] = '{has_next: (i + 1 < need), first: (i == 0), taken: 1'b1};
      end
      res.addr = heap_base_q + ADDR_W'(start) * ADDR_W'(BLOCK_SIZE);
      return res;
   endfunction

   function automatic status_type release_chain(logic [ADDR_W-1:0] faddr);
      int unsigned n, idx, i;
      entry_type   e;
      n = blocks_in_use();
      if (faddr < heap_base_q) return ST_RANGE;
      idx = (faddr - heap_base_q) / BLOCK_SIZE;
      if (idx >= n) return ST_RANGE;
      // clear along has-next, stop after the first entry without it
      for (i = idx; i < n; i++) begin
         e = block_marks[i];
         block_marks[i] = '0;
         if (!e.has_next) break;
      end
      return ST_OK;
   endfunction

   function automatic heap_reply_type apply_heap_command(logic [1:0] cmd,
                                                         logic [ADDR_W-1:0] size,
                                                         logic [ADDR_W-1:0] faddr);
      heap_reply_type res;
      res.addr = '0;
      res.status = ST_OK;
      case (cmd)
         CMD_ALLOC: res = carve_run(size);
         CMD_FREE:  res.status = release_chain(faddr);
         CMD_CLEAR: begin
            foreach (block_marks[k]) block_marks[k] = '0;
         end
         default: ;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Request side: bursts of back-to-back transactions with random gaps.
   // ---------------------------------------------------------------------
   int unsigned burst_left = 0;

   // Drive one transaction at the current edge and hold it until accepted.
   // Returns at the accepting edge with req_valid still high: the caller
   // either sends again right away or drops valid.
   task automatic send_request(input logic [1:0] cmd, input logic [ADDR_W-1:0] size,
                               input logic [ADDR_W-1:0] faddr);
      int unsigned    gap;
      heap_reply_type res;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_size_bytes <= size;
      req_free_addr  <= faddr;
      do @(posedge clock); while (!req_ready);
      res = apply_heap_command(cmd, size, faddr);
      if (cmd == CMD_ALLOC && res.status == ST_OK) live_blocks.push_back(res.addr);
      if (cmd == CMD_CLEAR) live_blocks.delete();
      owed_replies.push_back(res);
   endtask

   // Drop valid and hold until every owed reply has come back.
   task automatic drain_replies();
      req_valid <= 1'b0;
      burst_left = 0;
      while (owed_replies.size() != 0) @(posedge clock);
   endtask

   // One register write; the block is idle whenever this is called.
   task automatic write_csr(input csr_index_type idx, input logic [ADDR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_HEAP_BASE) heap_base_q = data;
      else block_count_q = data[BC_W-1:0];
   endtask

   task automatic set_heap(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] count);
      drain_replies();
      write_csr(CSR_HEAP_BASE, base);
      write_csr(CSR_BLOCK_COUNT, count);
   endtask

   // One random transaction, weighted toward allocate/free traffic that
   // reuses live addresses so the table fills, fragments and empties.
   task automatic send_random_command();
      int unsigned       pick, sub, kmax, k, idx;
      logic [ADDR_W-1:0] size, faddr;
      pick  = $urandom_range(0, 99);
      sub   = $urandom_range(0, 99);
      size  = $urandom;
      faddr = $urandom;
      kmax  = (blocks_in_use() > 6) ? 6 : ((blocks_in_use() == 0) ? 1 : blocks_in_use());
      if (pick < 52) begin
         if (sub < 80) begin
            k = $urandom_range(1, kmax);
            size = (k - 1) * BLOCK_SIZE + $urandom_range(1, BLOCK_SIZE);
         end else if (sub < 88) begin
            size = $urandom;
         end else if (sub < 93) begin
            size = '0;
         end else begin
            size = blocks_in_use() * BLOCK_SIZE + $urandom_range(0, 1);
         end
         send_request(CMD_ALLOC, size, faddr);
      end else if (pick < 86) begin
         if (live_blocks.size() != 0 && sub < 70) begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            faddr = live_blocks[idx];
            live_blocks.delete(idx);
            // an address inside the first block still names that block
            if ($urandom_range(0, 3) == 0) faddr += $urandom_range(1, BLOCK_SIZE - 1);
         end else if (sub < 85) begin
            // inner, free or just-beyond-the-end blocks
            faddr = heap_base_q + $urandom_range(0, blocks_in_use() + 2) * BLOCK_SIZE
                    + $urandom_range(0, BLOCK_SIZE - 1);
         end
         send_request(CMD_FREE, size, faddr);
      end else if (pick < 89) begin
         send_request(CMD_CLEAR, size, faddr);
      end else if (pick < 93) begin
         send_request(CMD_UNUSED, size, faddr);
      end else begin
         send_request(CMD_ALLOC, $urandom_range(1, BLOCK_SIZE), faddr);
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side: own stall pattern plus long hold-offs on demand.
   // ---------------------------------------------------------------------
   int unsigned hold_orders = 0;
   int unsigned hold_served = 0;
   int unsigned hold_len = 0;
   int unsigned hold_left = 0;
   int unsigned segment_left = 0;
   int unsigned rx_mode = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready    <= 1'b0;
         hold_left    <= 0;
         segment_left <= 0;
      end else if (hold_served != hold_orders) begin
         // start a long hold-off requested by the stimulus
         hold_served <= hold_orders;
         hold_left   <= hold_len;
         rsp_ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         // switch between always-ready, coin-flip and mostly-stalled stretches
         if (segment_left == 0) begin
            rx_mode      <= $urandom_range(0, 2);
            segment_left <= $urandom_range(8, 120);
         end else begin
            segment_left <= segment_left - 1;
         end
         case (rx_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= $urandom_range(0, 1);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("%s", msg);
   endfunction

   // Compare every accepted reply against the oldest owed one.
   always @(posedge clock) begin
      heap_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_replies.size() == 0) begin
            note_failure($sformatf("unexpected reply: addr %08h status %0d",
                                   rsp_alloc_addr, rsp_status));
         end else begin
            want = owed_replies.pop_front();
            if (rsp_alloc_addr !== want.addr || rsp_status !== want.status)
               note_failure($sformatf("reply mismatch: expected addr %08h status %s, got addr %08h status %0d",
                                      want.addr, want.status.name(), rsp_alloc_addr, rsp_status));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset defaults: base 0, full table. First fit, rounding, chains,
   // zero and oversize requests, frees of inner and free blocks, clear.
   task automatic test_first_fit_basics();
      send_request(CMD_ALLOC, 32'd1, '0);
      send_request(CMD_ALLOC, 32'd4096, '0);
      send_request(CMD_ALLOC, 32'd4097, '0);
      send_request(CMD_FREE, '0, 32'h0000_1abc);
      send_request(CMD_ALLOC, 32'd100, '0);
      send_request(CMD_ALLOC, 32'd0, 32'hffff_ffff);
      send_request(CMD_ALLOC, 32'hffff_ffff, '0);
      send_request(CMD_FREE, 32'hffff_ffff, 32'hffff_ffff);
      send_request(CMD_FREE, '0, 32'h0000_3000);
      send_request(CMD_FREE, '0, 32'h0000_5000);
      send_request(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
      send_request(CMD_CLEAR, '0, '0);
      // whole table as one run, then walk the full chain back
      send_request(CMD_ALLOC, NUM_BLOCKS_DEF * BLOCK_SIZE, '0);
      send_request(CMD_ALLOC, 32'd1, '0);
      send_request(CMD_FREE, '0, '0);
   endtask

   // Register extremes: a run cut off by the table end, frees below base and
   // beyond the table, zero block count, oversize count, address wrap.
   task automatic test_register_extremes();
      set_heap(32'h8000_0000, 32'd4);
      send_request(CMD_ALLOC, 32'd4096, '0);
      send_request(CMD_ALLOC, 32'd8192, '0);
      send_request(CMD_FREE, '0, 32'h8000_0000);
      send_request(CMD_ALLOC, 32'd8192, '0);
      send_request(CMD_FREE, '0, 32'h7fff_ffff);
      send_request(CMD_FREE, '0, 32'h8000_4000);
      set_heap(32'h8000_0000, 32'd0);
      send_request(CMD_ALLOC, 32'd1, '0);
      send_request(CMD_FREE, '0, 32'h8000_0000);
      set_heap(32'hffff_e000, 32'hffff_ffff);
      send_request(CMD_ALLOC, 32'd12288, '0);
      send_request(CMD_FREE, '0, 32'h0000_1000);
      send_request(CMD_CLEAR, '0, '0);
   endtask

   // Random traffic over a series of register settings, most of them with
   // short tables so a scan stays cheap, a few at the full depth.
   task automatic test_random_traffic();
      int unsigned       phase, items, count;
      logic [ADDR_W-1:0] base;
      for (phase = 0; phase < 14; phase++) begin
         items = 50;
         base  = ($urandom_range(0, 2) == 0) ? $urandom : ($urandom & 32'hffff_f000);
         count = $urandom_range(2, 48);
         case (phase)
            0: begin base = '0; count = 16; items = 40; end
            1: begin base = 32'hffff_0000; count = 32; items = 40; end
            2: begin count = 1; items = 20; end
            3: begin count = 0; items = 10; end
            4: begin count = NUM_BLOCKS_DEF; items = 15; end
            5: begin count = 2047; items = 10; end
            default: ;
         endcase
         // random upper bits on the count write; only the low field counts
         set_heap(base, ($urandom & ~32'h7ff) | count);
         repeat (items) send_random_command();
      end
   endtask

   // Hold the receiver off while requests keep coming so the block fills
   // and stalls its input, drain every reply, then repeat with a shorter hold.
   task automatic test_backpressure();
      set_heap(32'h0001_0000, 32'd8);
      hold_len    <= 3000;
      hold_orders <= hold_orders + 1;
      repeat (12) send_random_command();
      drain_replies();
      hold_len    <= 400;
      hold_orders <= hold_orders + 1;
      repeat (12) send_random_command();
   endtask

   initial begin
      // the block comes out of reset with every entry free
      foreach (block_marks[k]) block_marks[k] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_first_fit_basics();
      drain_replies();
      test_register_extremes();
      test_random_traffic();
      test_backpressure();
      drain_replies();
      // any reply arriving now has no owner and gets flagged by the checker
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("** first_fit_block_allocator_top: PASSED **");
      end else begin
         $display("** first_fit_block_allocator_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("** first_fit_block_allocator_top: FAILED **");
      $finish;
   end

endmodule
